[sv/ata_pio_sector_transfer_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// ATA PIO sequencer assertion macros
// Concurrent assertion helpers shared by the sequencer RTL. They vanish when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_SECTOR_TRANSFER_SEQUENCER_CORE_DEFINES_SVH
`define ATA_PIO_SECTOR_TRANSFER_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define APSS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define APSS_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define APSS_ASSERT(name, clk, rst_n, prop, msg)
`define APSS_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

[sv/apss_pkg.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer package
// Types, codes and beat decoding shared by the sequencer modules.
// ----------------------------------------------------------------------------
package apss_pkg;

	localparam int unsigned MAX_COUNT_DEF = 256;
	localparam int unsigned CFG_IDX_W     = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PART_START   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PART_SECTORS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUS_SELECT   = 2'd2;

	// Request types.
	localparam logic [2:0] REQ_READ   = 3'd0;
	localparam logic [2:0] REQ_WRITE  = 3'd1;
	localparam logic [2:0] REQ_STATUS = 3'd2;
	localparam logic [2:0] REQ_ERROR  = 3'd3;

	// Result kinds.
	localparam logic [1:0] KIND_REG_WR   = 2'd0;
	localparam logic [1:0] KIND_XFER     = 2'd1;
	localparam logic [1:0] KIND_FETCH_ER = 2'd2;
	localparam logic [1:0] KIND_DONE     = 2'd3;

	// Completion codes.
	localparam logic [2:0] CODE_OK        = 3'd0;
	localparam logic [2:0] CODE_BAD_COUNT = 3'd1;
	localparam logic [2:0] CODE_BEYOND_PT = 3'd2;
	localparam logic [2:0] CODE_BEYOND_28 = 3'd3;
	localparam logic [2:0] CODE_DEV_ERR   = 3'd4;
	localparam logic [2:0] CODE_FAULT     = 3'd5;
	localparam logic [2:0] CODE_NO_DRQ    = 3'd6;

	// Task file offsets.
	localparam logic [2:0] TF_COUNT = 3'd2;
	localparam logic [2:0] TF_LBA0  = 3'd3;
	localparam logic [2:0] TF_LBA1  = 3'd4;
	localparam logic [2:0] TF_LBA2  = 3'd5;
	localparam logic [2:0] TF_DRIVE = 3'd6;
	localparam logic [2:0] TF_CMD   = 3'd7;

	// Status register bits.
	localparam int unsigned ST_BSY = 7;
	localparam int unsigned ST_RDY = 6;
	localparam int unsigned ST_DF  = 5;
	localparam int unsigned ST_DRQ = 3;
	localparam int unsigned ST_ERR = 0;

	localparam logic [7:0]  DH_BASE     = 8'hE0;
	localparam logic [7:0]  CMD_READ    = 8'h20;
	localparam logic [7:0]  CMD_WRITE   = 8'h30;
	localparam logic [33:0] LBA28_LIMIT = 34'h0_1000_0000;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_READY,
		PH_POLL,
		PH_ERRF,
		PH_FLUSH
	} phase_t;

	// How a registered result group unfolds into beats.
	typedef enum logic [1:0] {
		BND_SINGLE,
		BND_TASKFILE,
		BND_XFER_DONE
	} bmode_t;

	typedef struct packed {
		bmode_t      mode;
		logic [1:0]  kind;
		logic [2:0]  reg_addr;
		logic [7:0]  reg_data;
		logic        direction;
		logic [2:0]  code;
		logic [7:0]  err_byte;
		logic [7:0]  count_byte;
		logic [27:0] abs_sector;
	} bundle_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] reg_addr;
		logic [7:0] reg_data;
		logic       direction;
		logic [2:0] code;
		logic [7:0] err_byte;
	} beat_t;

	function automatic logic [2:0] beat_count(input bmode_t mode);
		case (mode)
			BND_TASKFILE:  return 3'd6;
			BND_XFER_DONE: return 3'd2;
			default:       return 3'd1;
		endcase
	endfunction

	function automatic beat_t beat_of(input bundle_t b, input logic [2:0] idx);
		beat_t r;
		r = '0;
		r.direction = b.direction;
		case (b.mode)
			BND_TASKFILE: begin
				r.kind = KIND_REG_WR;
				case (idx)
					3'd0: begin
						r.reg_addr = TF_COUNT;
						r.reg_data = b.count_byte;
					end
					3'd1: begin
						r.reg_addr = TF_LBA0;
						r.reg_data = b.abs_sector[7:0];
					end
					3'd2: begin
						r.reg_addr = TF_LBA1;
						r.reg_data = b.abs_sector[15:8];
					end
					3'd3: begin
						r.reg_addr = TF_LBA2;
						r.reg_data = b.abs_sector[23:16];
					end
					3'd4: begin
						r.reg_addr = TF_DRIVE;
						r.reg_data = DH_BASE | {4'h0, b.abs_sector[27:24]};
					end
					default: begin
						r.reg_addr = TF_CMD;
						r.reg_data = b.direction ? CMD_WRITE : CMD_READ;
					end
				endcase
			end
			BND_XFER_DONE: begin
				r.kind = (idx == 3'd0) ? KIND_XFER : KIND_DONE;
				r.code = CODE_OK;
			end
			default: begin
				r.kind     = b.kind;
				r.reg_addr = b.reg_addr;
				r.reg_data = b.reg_data;
				r.code     = b.code;
				r.err_byte = b.err_byte;
			end
		endcase
		return r;
	endfunction

endpackage

[sv/apss_ctrl.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer control
// Request checks and the phase machine; turns each accepted item into a
// group of results for the beat stage.
// ----------------------------------------------------------------------------
`include "ata_pio_sector_transfer_sequencer_core_defines.svh"

module apss_ctrl #(
	parameter int unsigned MAX_COUNT = apss_pkg::MAX_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [2:0]        req_type,
	input  logic [31:0]       lba,
	input  logic [8:0]        sec_cnt,
	input  logic [7:0]        dev_byte,
	input  logic [31:0]       partition_start,
	input  logic [31:0]       partition_sectors,
	output apss_pkg::bundle_t bnd,
	output logic              bnd_load
);
	import apss_pkg::*;

	localparam logic [8:0] MaxCnt = 9'(MAX_COUNT);

	phase_t      phase_q, phase_d;
	logic [8:0]  remaining_q, remaining_d;
	logic [8:0]  total_count_q, total_count_d;
	logic [27:0] abs_sector_q, abs_sector_d;
	logic        is_write_q, is_write_d;

	logic        bad_count;
	logic        beyond_part;
	logic        beyond_28;
	logic [32:0] abs_start;
	logic [32:0] part_end;
	logic [33:0] abs_end;

	// Sums are kept wide enough that nothing wraps.
	assign bad_count   = (sec_cnt == 9'd0) || (sec_cnt > MaxCnt);
	assign part_end    = {1'b0, lba} + 33'(sec_cnt);
	assign beyond_part = part_end > {1'b0, partition_sectors};
	assign abs_start   = {1'b0, partition_start} + {1'b0, lba};
	assign abs_end     = {1'b0, abs_start} + 34'(sec_cnt);
	assign beyond_28   = abs_end > LBA28_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			remaining_q   <= '0;
			total_count_q <= '0;
			abs_sector_q  <= '0;
			is_write_q    <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			remaining_q   <= remaining_d;
			total_count_q <= total_count_d;
			abs_sector_q  <= abs_sector_d;
			is_write_q    <= is_write_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		remaining_d    = remaining_q;
		total_count_d  = total_count_q;
		abs_sector_d   = abs_sector_q;
		is_write_d     = is_write_q;
		bnd            = '0;
		bnd.mode       = BND_SINGLE;
		bnd.direction  = is_write_q;
		bnd.count_byte = total_count_q[7:0];
		bnd.abs_sector = abs_sector_q;
		bnd_load       = 1'b0;
		if (take) begin
			case (req_type)
				REQ_READ, REQ_WRITE: begin
					if (phase_q == PH_IDLE) begin
						is_write_d    = req_type[0];
						bnd.direction = req_type[0];
						bnd_load      = 1'b1;
						bnd.kind      = KIND_DONE;
						if (bad_count) begin
							bnd.code = CODE_BAD_COUNT;
						end else if (beyond_part) begin
							bnd.code = CODE_BEYOND_PT;
						end else if (beyond_28) begin
							bnd.code = CODE_BEYOND_28;
						end else begin
							bnd.kind      = KIND_REG_WR;
							bnd.reg_addr  = TF_DRIVE;
							bnd.reg_data  = DH_BASE;
							abs_sector_d  = abs_start[27:0];
							total_count_d = sec_cnt;
							remaining_d   = sec_cnt;
							phase_d       = PH_READY;
						end
					end
				end
				REQ_STATUS: begin
					case (phase_q)
						PH_READY: begin
							if (!dev_byte[ST_BSY] && dev_byte[ST_RDY]) begin
								bnd.mode = BND_TASKFILE;
								bnd_load = 1'b1;
								phase_d  = PH_POLL;
							end
						end
						PH_POLL: begin
							if (!dev_byte[ST_BSY]) begin
								bnd_load = 1'b1;
								if (dev_byte[ST_ERR]) begin
									bnd.kind = KIND_FETCH_ER;
									phase_d  = PH_ERRF;
								end else if (dev_byte[ST_DF]) begin
									bnd.kind = KIND_DONE;
									bnd.code = CODE_FAULT;
									phase_d  = PH_IDLE;
								end else if (!dev_byte[ST_DRQ]) begin
									bnd.kind = KIND_DONE;
									bnd.code = CODE_NO_DRQ;
									phase_d  = PH_IDLE;
								end else begin
									bnd.kind    = KIND_XFER;
									remaining_d = remaining_q - 9'd1;
									if (remaining_q == 9'd1) begin
										if (is_write_q) begin
											phase_d = PH_FLUSH;
										end else begin
											bnd.mode = BND_XFER_DONE;
											phase_d  = PH_IDLE;
										end
									end
								end
							end
						end
						PH_FLUSH: begin
							if (!dev_byte[ST_BSY]) begin
								bnd_load = 1'b1;
								bnd.kind = KIND_DONE;
								phase_d  = PH_IDLE;
							end
						end
						default: ;
					endcase
				end
				REQ_ERROR: begin
					if (phase_q == PH_ERRF) begin
						bnd_load     = 1'b1;
						bnd.kind     = KIND_DONE;
						bnd.code     = CODE_DEV_ERR;
						bnd.err_byte = dev_byte;
						phase_d      = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	`APSS_ASSERT(a_ready_counts, clk, arst_n, (phase_q == PH_READY) |-> (remaining_q == total_count_q && remaining_q != 9'd0), "count mismatch while waiting for ready")
	`APSS_ASSERT_NEVER(a_poll_nonzero, clk, arst_n, phase_q == PH_POLL && remaining_q == 9'd0, "polling with no sectors left")
	`APSS_ASSERT(a_leave_idle, clk, arst_n, (phase_q == PH_IDLE && phase_d != PH_IDLE) |-> (bnd_load && phase_d == PH_READY), "idle left without a drive select")

endmodule

[sv/apss_beat.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer beat stage
// Holds one result group; hands out one beat per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`include "ata_pio_sector_transfer_sequencer_core_defines.svh"

module apss_beat (
	input  logic              clk,
	input  logic              arst_n,
	input  apss_pkg::bundle_t bnd,
	input  logic              bnd_load,
	output logic              space,
	output logic              m_tvalid,
	input  logic              m_tready,
	output apss_pkg::beat_t   beat,
	output logic              m_tlast
);
	import apss_pkg::*;

	bundle_t    bnd_s1;
	logic       valid_s1;
	logic [2:0] idx_q;
	logic [2:0] nbeats;
	logic       drain;

	assign nbeats     = beat_count(bnd_s1.mode);
	assign m_tlast    = (idx_q == nbeats - 3'd1);
	assign m_tvalid   = valid_s1;
	assign drain      = valid_s1 && m_tready && m_tlast;
	assign space      = !valid_s1 || drain;
	assign beat       = beat_of(bnd_s1, idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (bnd_load) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (drain) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (valid_s1 && m_tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_load) begin
			bnd_s1 <= bnd;
		end
	end

	`APSS_ASSERT_NEVER(a_idx_range, clk, arst_n, valid_s1 && idx_q >= nbeats, "beat index past group end")
	`APSS_ASSERT(a_group_holds, clk, arst_n, (valid_s1 && m_tready && !m_tlast && !bnd_load) |=> valid_s1, "group dropped before its last beat")
	`APSS_ASSERT_NEVER(a_load_busy, clk, arst_n, bnd_load && !space, "group loaded over an unfinished one")

endmodule

[sv/ata_pio_sector_transfer_sequencer_core.sv]
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sector transfer sequencer
// Host-side sequencer: checks read and write requests, then steps through
// drive select, task file writes, per-sector status polling and completion.
// ----------------------------------------------------------------------------
// Usage. Items enter on the s_axis stream: tuser carries the item type
// (read request, write request, status byte, error byte, idle tick) and
// tdata the start sector, sector count and device byte. Each item is handled
// in the cycle it is accepted; the results it causes are registered as one
// group and leave on the m_axis stream one beat per cycle, starting the cycle
// after acceptance. tuser on the output is the result kind and tlast marks the
// last beat caused by one input item. Items that cause no result are simply
// consumed.
// Throughput is one item per cycle while each item yields a single beat. The
// status sample that releases the task file writes yields six beats and a
// final read sector yields two; s_axis_tready stays low until the last beat of
// the held group is taken, so the beat stage sets the rate. When the receiver
// stalls, the held beat stays on m_axis and input is taken only once the
// group drains. The cfg channel is always ready; the user must write registers
// only while the sequencer is idle; the block does not enforce it. Reset clears
// the phase machine, counters and config registers, and leaves no beat pending.
// ----------------------------------------------------------------------------
module ata_pio_sector_transfer_sequencer_core #(
	parameter int unsigned MAX_COUNT = apss_pkg::MAX_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [55:0]                    s_axis_tdata, // lba[31:0], sec_cnt[40:32], dev_byte[48:41], zero pad
	input  logic [2:0]                     s_axis_tuser, // req_type[2:0]
	// Result stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [23:0]                    m_axis_tdata, // bus[0], reg_addr[3:1], reg_data[11:4], direction[12], code[15:13], err_byte[23:16]
	output logic [1:0]                     m_axis_tuser, // kind[1:0]
	output logic                           m_axis_tlast,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [apss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import apss_pkg::*;

	logic [31:0] part_start_q;
	logic [31:0] part_sectors_q;
	logic        bus_select_q;
	logic        take;
	logic        space;
	bundle_t     bnd;
	logic        bnd_load;
	beat_t       beat;

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_start_q   <= '0;
			part_sectors_q <= '0;
			bus_select_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PART_START:   part_start_q   <= cfg_data;
				CFG_PART_SECTORS: part_sectors_q <= cfg_data;
				CFG_BUS_SELECT:   bus_select_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// An item is taken whenever the beat stage can hold its results.
	assign s_axis_tready = space;
	assign take          = s_axis_tvalid && s_axis_tready;

	apss_ctrl #(
		.MAX_COUNT(MAX_COUNT)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.take              (take),
		.req_type          (s_axis_tuser),
		.lba               (s_axis_tdata[31:0]),
		.sec_cnt           (s_axis_tdata[40:32]),
		.dev_byte          (s_axis_tdata[48:41]),
		.partition_start   (part_start_q),
		.partition_sectors (part_sectors_q),
		.bnd               (bnd),
		.bnd_load          (bnd_load)
	);

	apss_beat u_beat (
		.clk      (clk),
		.arst_n   (arst_n),
		.bnd      (bnd),
		.bnd_load (bnd_load),
		.space    (space),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.beat     (beat),
		.m_tlast  (m_axis_tlast)
	);

	// The bus field always follows the current bus selection.
	assign m_axis_tuser = beat.kind;
	assign m_axis_tdata = {beat.err_byte, beat.code, beat.direction,
		beat.reg_data, beat.reg_addr, bus_select_q};

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for the ATA PIO LBA28 sector transfer sequencer
// Drives request, status and error-byte beats into the sequencer and checks
// every result beat against an in-bench prediction or a typed-in beat. A short
// directed table comes first, then random transfers under several partition
// and bus settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import apss_pkg::*;

	// Item types that have no name in the package: both are consumed silently.
	localparam logic [2:0] REQ_TICK  = 3'd4;
	localparam logic [2:0] REQ_SPARE = 3'd7;

	localparam int unsigned RANDOM_ITEMS = 170;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	// One result beat, unpacked from tuser, tdata and tlast.
	typedef struct packed {
		logic [1:0] kind;
		logic       bus;
		logic [2:0] reg_addr;
		logic [7:0] reg_data;
		logic       direction;
		logic [2:0] code;
		logic [7:0] err_byte;
		logic       last;
	} seq_beat_t;

	// How a row of the directed table is handled. Predicted rows take their
	// expected beats from the prediction; silent rows must produce nothing;
	// completion rows carry their single completion beat typed in; register
	// rows write a configuration register instead of sending a beat.
	typedef enum logic [1:0] {
		ROW_PREDICTED,
		ROW_SILENT,
		ROW_COMPLETION,
		ROW_REGISTER
	} row_kind_t;

	typedef struct packed {
		row_kind_t                how;
		logic [2:0]               req;
		logic [31:0]              lba;
		logic [8:0]               cnt;
		logic [7:0]               dev;
		logic [CFG_IDX_W-1:0]     reg_idx;
		seq_beat_t                want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [55:0]          s_axis_tdata = '0;
	logic [2:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	ata_pio_sector_transfer_sequencer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow of the configuration registers, updated on each accepted write.
	logic [31:0] part_start;
	logic [31:0] part_size;
	logic        bus_sel;

	// Shadow of the sequencer state.
	phase_t      seq_phase;
	logic [8:0]  left_cnt;
	logic [8:0]  total_sectors;
	logic [27:0] lba_abs;
	logic        wr_req;

	// Beats caused by the item just accepted, and beats still owed by the
	// sequencer, oldest first.
	seq_beat_t   fresh_beats[$];
	seq_beat_t   pending_beats[$];

	int unsigned productive_items = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	// While set, neither stream idles or stalls.
	bit          calm = 1'b0;

	stim_row_t   plan[$];

	initial begin
		forever #6 clk = ~clk;
	end

	// Bus and direction always reflect the current setting and the request
	// in progress at the time the beat is predicted.
	function automatic seq_beat_t make_beat(input logic [1:0] kind, input logic [2:0] addr,
			input logic [7:0] data, input logic [2:0] code, input logic [7:0] err);
		seq_beat_t b;
		b.kind      = kind;
		b.bus       = bus_sel;
		b.reg_addr  = addr;
		b.reg_data  = data;
		b.direction = wr_req;
		b.code      = code;
		b.err_byte  = err;
		b.last      = 1'b0;
		return b;
	endfunction

	// Steps the shadow sequencer by one accepted item and leaves the beats it
	// causes in fresh_beats, the final one marked last.
	function automatic void advance_sequencer(input logic [2:0] req, input logic [31:0] lba,
			input logic [8:0] cnt, input logic [7:0] dev);
		logic [33:0] span_end;
		logic [33:0] abs_first;
		logic [33:0] abs_end;
		seq_beat_t   tail;
		fresh_beats.delete();
		if (req == REQ_READ || req == REQ_WRITE) begin
			// A request while a transfer is under way is dropped untouched.
			if (seq_phase == PH_IDLE) begin
				wr_req    = (req == REQ_WRITE);
				span_end  = {2'b00, lba} + {25'd0, cnt};
				abs_first = {2'b00, part_start} + {2'b00, lba};
				abs_end   = abs_first + {25'd0, cnt};
				// Count is checked first, then the partition, then LBA28; all
				// sums are wide enough that nothing wraps.
				if (cnt == 9'd0 || cnt > MAX_COUNT_DEF) begin
					fresh_beats.push_back(make_beat(KIND_DONE, '0, '0, CODE_BAD_COUNT, '0));
				end else if (span_end > {2'b00, part_size}) begin
					fresh_beats.push_back(make_beat(KIND_DONE, '0, '0, CODE_BEYOND_PT, '0));
				end else if (abs_end > LBA28_LIMIT) begin
					fresh_beats.push_back(make_beat(KIND_DONE, '0, '0, CODE_BEYOND_28, '0));
				end else begin
					lba_abs       = abs_first[27:0];
					total_sectors = cnt;
					left_cnt      = cnt;
					seq_phase     = PH_READY;
					fresh_beats.push_back(make_beat(KIND_REG_WR, TF_DRIVE, DH_BASE, CODE_OK, '0));
				end
			end
		end else if (req == REQ_STATUS) begin
			case (seq_phase)
				PH_READY: begin
					// Only a sample with BSY clear and RDY set releases the task file.
					if (!dev[ST_BSY] && dev[ST_RDY]) begin
						fresh_beats.push_back(make_beat(KIND_REG_WR, TF_COUNT, total_sectors[7:0],
							CODE_OK, '0));
						fresh_beats.push_back(make_beat(KIND_REG_WR, TF_LBA0, lba_abs[7:0], CODE_OK, '0));
						fresh_beats.push_back(make_beat(KIND_REG_WR, TF_LBA1, lba_abs[15:8], CODE_OK, '0));
						fresh_beats.push_back(make_beat(KIND_REG_WR, TF_LBA2, lba_abs[23:16], CODE_OK,
							'0));
						fresh_beats.push_back(make_beat(KIND_REG_WR, TF_DRIVE,
							DH_BASE | {4'h0, lba_abs[27:24]}, CODE_OK, '0));
						fresh_beats.push_back(make_beat(KIND_REG_WR, TF_CMD,
							wr_req ? CMD_WRITE : CMD_READ, CODE_OK, '0));
						seq_phase = PH_POLL;
					end
				end
				PH_POLL: begin
					// ERR wins over DF, and DF over a missing DRQ.
					if (!dev[ST_BSY]) begin
						if (dev[ST_ERR]) begin
							seq_phase = PH_ERRF;
							fresh_beats.push_back(make_beat(KIND_FETCH_ER, '0, '0, CODE_OK, '0));
						end else if (dev[ST_DF]) begin
							seq_phase = PH_IDLE;
							fresh_beats.push_back(make_beat(KIND_DONE, '0, '0, CODE_FAULT, '0));
						end else if (!dev[ST_DRQ]) begin
							seq_phase = PH_IDLE;
							fresh_beats.push_back(make_beat(KIND_DONE, '0, '0, CODE_NO_DRQ, '0));
						end else begin
							fresh_beats.push_back(make_beat(KIND_XFER, '0, '0, CODE_OK, '0));
							left_cnt = left_cnt - 9'd1;
							if (left_cnt == 9'd0) begin
								// A write still has to see BSY drop before it completes.
								if (wr_req) begin
									seq_phase = PH_FLUSH;
								end else begin
									seq_phase = PH_IDLE;
									fresh_beats.push_back(make_beat(KIND_DONE, '0, '0, CODE_OK, '0));
								end
							end
						end
					end
				end
				PH_FLUSH: begin
					if (!dev[ST_BSY]) begin
						seq_phase = PH_IDLE;
						fresh_beats.push_back(make_beat(KIND_DONE, '0, '0, CODE_OK, '0));
					end
				end
				default: begin
				end
			endcase
		end else if (req == REQ_ERROR && seq_phase == PH_ERRF) begin
			seq_phase = PH_IDLE;
			fresh_beats.push_back(make_beat(KIND_DONE, '0, '0, CODE_DEV_ERR, dev));
		end
		if (fresh_beats.size() != 0) begin
			tail = fresh_beats.pop_back();
			tail.last = 1'b1;
			fresh_beats.push_back(tail);
		end
	endfunction

	// Table row builders.
	function automatic stim_row_t stim_row(input logic [2:0] req, input logic [31:0] lba,
			input logic [8:0] cnt, input logic [7:0] dev);
		stim_row_t r;
		r = '0;
		r.how = ROW_PREDICTED;
		r.req = req;
		r.lba = lba;
		r.cnt = cnt;
		r.dev = dev;
		return r;
	endfunction

	function automatic stim_row_t silent_row(input logic [2:0] req, input logic [31:0] lba,
			input logic [8:0] cnt, input logic [7:0] dev);
		stim_row_t r;
		r = stim_row(req, lba, cnt, dev);
		r.how = ROW_SILENT;
		return r;
	endfunction

	function automatic stim_row_t done_row(input logic [2:0] req, input logic [31:0] lba,
			input logic [8:0] cnt, input logic [7:0] dev, input logic bus, input logic dir,
			input logic [2:0] code, input logic [7:0] err);
		stim_row_t r;
		r = stim_row(req, lba, cnt, dev);
		r.how            = ROW_COMPLETION;
		r.want.kind      = KIND_DONE;
		r.want.bus       = bus;
		r.want.direction = dir;
		r.want.code      = code;
		r.want.err_byte  = err;
		r.want.last      = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		stim_row_t r;
		r = '0;
		r.how     = ROW_REGISTER;
		r.reg_idx = idx;
		r.lba     = value;
		return r;
	endfunction

	// Lowers tvalid and waits until every owed beat has been taken.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0)
			@(negedge clk);
	endtask

	// Registers are only written with the sequencer idle and drained. An item
	// that causes nothing may still be in flight, so the write waits past the drain.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_PART_START:   part_start = value;
			CFG_PART_SECTORS: part_size  = value;
			CFG_BUS_SELECT:   bus_sel    = value[0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sends one item, waits for it to be taken and records the beats owed.
	task automatic send_item(input logic [2:0] req, input logic [31:0] lba, input logic [8:0] cnt,
			input logic [7:0] dev, input row_kind_t how, input seq_beat_t want);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {7'd0, dev, cnt, lba};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		advance_sequencer(req, lba, cnt, dev);
		if (fresh_beats.size() != 0)
			productive_items++;
		case (how)
			ROW_PREDICTED: begin
				foreach (fresh_beats[i])
					pending_beats.push_back(fresh_beats[i]);
			end
			ROW_COMPLETION: pending_beats.push_back(want);
			default: begin
			end
		endcase
	endtask

	// The receiver stalls with a chance of nine in a hundred unless calm.
	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
	end

	// Every result beat is matched against the oldest owed beat.
	always @(posedge clk) begin : result_check
		seq_beat_t got;
		seq_beat_t owed;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind      = m_axis_tuser;
			got.bus       = m_axis_tdata[0];
			got.reg_addr  = m_axis_tdata[3:1];
			got.reg_data  = m_axis_tdata[11:4];
			got.direction = m_axis_tdata[12];
			got.code      = m_axis_tdata[15:13];
			got.err_byte  = m_axis_tdata[23:16];
			got.last      = m_axis_tlast;
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected result beat kind=%0d bus=%0d addr=%0d data=%02h dir=%0d",
					$realtime, got.kind, got.bus, got.reg_addr, got.reg_data, got.direction,
					" code=%0d err=%02h last=%0d", got.code, got.err_byte, got.last);
				errors++;
			end else begin
				owed = pending_beats.pop_front();
				if (got !== owed) begin
					$display("%0t: result mismatch, expected kind=%0d bus=%0d addr=%0d data=%02h",
						$realtime, owed.kind, owed.bus, owed.reg_addr, owed.reg_data,
						" dir=%0d code=%0d err=%02h last=%0d", owed.direction, owed.code,
						owed.err_byte, owed.last,
						", actual kind=%0d bus=%0d addr=%0d data=%02h", got.kind, got.bus,
						got.reg_addr, got.reg_data,
						" dir=%0d code=%0d err=%02h last=%0d", got.direction, got.code,
						got.err_byte, got.last);
					errors++;
				end
			end
		end
	end

	// Hard stop in case the sequencer hangs or stops answering.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned setting;
		int unsigned sofar;
		int unsigned base;
		int unsigned roll;
		logic [2:0]  req;
		logic [31:0] lba;
		logic [8:0]  cnt;
		logic [7:0]  dev;
		logic [31:0] word;

		part_start    = '0;
		part_size     = '0;
		bus_sel       = 1'b0;
		seq_phase     = PH_IDLE;
		left_cnt      = '0;
		total_sectors = '0;
		lba_abs       = '0;
		wr_req        = 1'b0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. With the reset setting the partition is empty, so
		// every well-sized request is out of bounds.
		plan.push_back(done_row(REQ_READ, 32'd0, 9'd0, 8'h00, 1'b0, 1'b0, CODE_BAD_COUNT, 8'h00));
		plan.push_back(done_row(REQ_WRITE, 32'hFFFF_FFFF, 9'd511, 8'hFF, 1'b0, 1'b1,
			CODE_BAD_COUNT, 8'h00));
		plan.push_back(done_row(REQ_READ, 32'd0, 9'd1, 8'h00, 1'b0, 1'b0, CODE_BEYOND_PT, 8'h00));
		// Status and error bytes that nobody asked for, and idle ticks.
		plan.push_back(silent_row(REQ_STATUS, 32'd0, 9'd0, 8'hFF));
		plan.push_back(silent_row(REQ_ERROR, 32'd0, 9'd0, 8'hFF));
		plan.push_back(silent_row(REQ_TICK, 32'hFFFF_FFFF, 9'd511, 8'hFF));
		plan.push_back(silent_row(REQ_SPARE, 32'd0, 9'd0, 8'h00));
		// Full-size partition on the secondary bus.
		plan.push_back(reg_row(CFG_PART_SECTORS, 32'hFFFF_FFFF));
		plan.push_back(reg_row(CFG_BUS_SELECT, 32'd1));
		// The end of the range would wrap in 32 bits; it must still be refused.
		plan.push_back(done_row(REQ_READ, 32'hFFFF_FFFF, 9'd256, 8'h00, 1'b1, 1'b0,
			CODE_BEYOND_PT, 8'h00));
		plan.push_back(done_row(REQ_WRITE, 32'h0FFF_FFFF, 9'd2, 8'h00, 1'b1, 1'b1,
			CODE_BEYOND_28, 8'h00));
		// The last addressable sector, written: drive select, waits on a busy
		// and a not-ready sample, task file, one sector, then the flush.
		plan.push_back(stim_row(REQ_WRITE, 32'h0FFF_FFFF, 9'd1, 8'h00));
		plan.push_back(silent_row(REQ_STATUS, 32'd0, 9'd0, 8'hC0));
		plan.push_back(silent_row(REQ_STATUS, 32'd0, 9'd0, 8'h00));
		plan.push_back(stim_row(REQ_STATUS, 32'd0, 9'd0, 8'h40));
		plan.push_back(silent_row(REQ_READ, 32'd0, 9'd1, 8'h00));
		plan.push_back(stim_row(REQ_STATUS, 32'd0, 9'd0, 8'h08));
		plan.push_back(silent_row(REQ_STATUS, 32'd0, 9'd0, 8'h88));
		plan.push_back(stim_row(REQ_STATUS, 32'd0, 9'd0, 8'h7F));
		// A 256-sector partition that ends exactly at the LBA28 limit.
		plan.push_back(reg_row(CFG_PART_START, 32'h0FFF_FF00));
		plan.push_back(reg_row(CFG_PART_SECTORS, 32'h0000_0100));
		plan.push_back(reg_row(CFG_BUS_SELECT, 32'd0));
		// A full 256-sector read (count register gets zero) that ends in a
		// device error fetched through the error register.
		plan.push_back(stim_row(REQ_READ, 32'd0, 9'd256, 8'h00));
		plan.push_back(stim_row(REQ_STATUS, 32'd0, 9'd0, 8'h40));
		plan.push_back(silent_row(REQ_STATUS, 32'd0, 9'd0, 8'h80));
		plan.push_back(stim_row(REQ_STATUS, 32'd0, 9'd0, 8'h08));
		plan.push_back(silent_row(REQ_ERROR, 32'd0, 9'd0, 8'h00));
		plan.push_back(stim_row(REQ_STATUS, 32'd0, 9'd0, 8'h29));
		plan.push_back(silent_row(REQ_STATUS, 32'd0, 9'd0, 8'h40));
		plan.push_back(done_row(REQ_ERROR, 32'd0, 9'd0, 8'hA5, 1'b0, 1'b0, CODE_DEV_ERR, 8'hA5));
		// Drive fault during a write, then a read that sees no DRQ.
		plan.push_back(stim_row(REQ_WRITE, 32'h0000_00FF, 9'd1, 8'h00));
		plan.push_back(stim_row(REQ_STATUS, 32'd0, 9'd0, 8'h40));
		plan.push_back(done_row(REQ_STATUS, 32'd0, 9'd0, 8'h28, 1'b0, 1'b1, CODE_FAULT, 8'h00));
		plan.push_back(stim_row(REQ_READ, 32'd0, 9'd1, 8'h00));
		plan.push_back(stim_row(REQ_STATUS, 32'd0, 9'd0, 8'h41));
		plan.push_back(done_row(REQ_STATUS, 32'd0, 9'd0, 8'h00, 1'b0, 1'b0, CODE_NO_DRQ, 8'h00));

		foreach (plan[i]) begin
			if (plan[i].how == ROW_REGISTER)
				write_reg(plan[i].reg_idx, plan[i].lba);
			else
				send_item(plan[i].req, plan[i].lba, plan[i].cnt, plan[i].dev, plan[i].how,
					plan[i].want);
		end

		// Random part: whole transfers with random content, interrupted now and
		// then by noise. Every transfer runs until the sequencer is idle again,
		// so the setting can change between transfers.
		base    = productive_items;
		setting = 0;
		while (productive_items - base < RANDOM_ITEMS) begin
			sofar = productive_items - base;
			if (sofar >= setting * 30) begin
				case (setting % 6)
					0: begin
						write_reg(CFG_PART_START, 32'd0);
						write_reg(CFG_PART_SECTORS, 32'hFFFF_FFFF);
					end
					1: begin
						write_reg(CFG_PART_START, $urandom_range(0, 32'h0FFF_0000));
						write_reg(CFG_PART_SECTORS, $urandom_range(16, 4096));
					end
					2: begin
						write_reg(CFG_PART_START, 32'h0FFF_FFF0);
						write_reg(CFG_PART_SECTORS, 32'hFFFF_FFFF);
					end
					3: begin
						write_reg(CFG_PART_START, 32'hFFFF_FFFF);
						write_reg(CFG_PART_SECTORS, 32'hFFFF_FFFF);
					end
					4: begin
						write_reg(CFG_PART_START, $urandom);
						write_reg(CFG_PART_SECTORS, $urandom);
					end
					default: begin
						write_reg(CFG_PART_START, 32'd0);
						write_reg(CFG_PART_SECTORS, 32'd0);
					end
				endcase
				word = $urandom;
				write_reg(CFG_BUS_SELECT, {31'd0, word[0]});
				setting++;
			end
			// A long stretch with no idling on either stream.
			calm = (sofar >= 90 && sofar < 140);
			// Sometimes hold off until the sequencer has caught up completely.
			if ($urandom_range(0, 99) < 5)
				wait_drained();
			// Stray status, error and idle beats between transfers.
			if ($urandom_range(0, 99) < 10) begin
				req = 3'($urandom_range(2, 7));
				send_item(req, $urandom, 9'($urandom), 8'($urandom), ROW_PREDICTED, '0);
			end

			// Mostly short transfers; a few full-size or out-of-range counts.
			roll = $urandom_range(0, 99);
			if (roll < 70)
				cnt = 9'($urandom_range(1, 4));
			else if (roll < 85)
				cnt = 9'($urandom_range(5, 24));
			else if (roll < 90)
				cnt = 9'd256;
			else
				cnt = 9'($urandom_range(0, 511));
			// Start inside the partition, near its end, or anywhere at all.
			roll = $urandom_range(0, 99);
			if (roll < 65)
				lba = (part_size == 0) ? 32'd0 :
					$urandom_range(0, (part_size > 300) ? 300 : part_size - 1);
			else if (roll < 80)
				lba = part_size - $urandom_range(0, 8);
			else
				lba = $urandom;
			req = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
			send_item(req, lba, cnt, 8'($urandom), ROW_PREDICTED, '0);

			while (seq_phase != PH_IDLE) begin
				word = $urandom;
				dev  = word[7:0];
				roll = $urandom_range(0, 99);
				if (roll < 7) begin
					// Noise: any item type with random fields.
					req = 3'($urandom_range(0, 7));
					send_item(req, $urandom, 9'($urandom), dev, ROW_PREDICTED, '0);
				end else begin
					req  = REQ_STATUS;
					roll = $urandom_range(0, 99);
					case (seq_phase)
						PH_READY: begin
							if (roll < 80) begin
								dev = (dev & 8'h3F) | 8'h40;
							end else if (!dev[ST_BSY] && dev[ST_RDY]) begin
								dev[ST_BSY] = 1'b1;
							end
						end
						PH_POLL: begin
							if (roll < 75)
								dev = (dev & 8'h56) | 8'h08;
							else if (roll < 81)
								dev = dev | 8'h80;
							else if (roll < 85)
								dev = (dev & 8'h7F) | 8'h01;
							else if (roll < 89)
								dev = (dev & 8'h7E) | 8'h20;
							else
								dev = dev & 8'h56;
						end
						PH_FLUSH: begin
							if (roll < 70)
								dev = dev & 8'h7F;
							else
								dev = dev | 8'h80;
						end
						default: req = REQ_ERROR;
					endcase
					send_item(req, $urandom, 9'($urandom), dev, ROW_PREDICTED, '0);
				end
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

[ata_pio_sector_transfer_sequencer_core.f]
+incdir+sv
sv/apss_pkg.sv
sv/apss_ctrl.sv
sv/apss_beat.sv
sv/ata_pio_sector_transfer_sequencer_core.sv
bench/testbench.sv
